### hw/rtl/segment_reorder_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// segment_reorder_receiver_unit_assert.svh
// Assertion macros for the segment reorder receiver. The macros expand to
// nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_REORDER_RECEIVER_UNIT_ASSERT_SVH
`define SEGMENT_REORDER_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset
`define SRR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define SRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

### hw/rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Constants, codes and types of the segment reorder receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

	// Table and protocol sizes
	localparam int SLOTS        = 8;
	localparam int MAX_SEGMENT  = 1024;
	localparam int DRAIN_PASSES = 2;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PASS_W = (DRAIN_PASSES > 1) ? $clog2(DRAIN_PASSES) : 1;

	// Field widths
	localparam int SEQ_W     = 32;
	localparam int LEN_W     = 11;
	localparam int BYTES_W   = 16;
	localparam int OUTCOME_W = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_W     = 32;
	localparam int ENTRY_W   = SEQ_W + LEN_W;

	// Stream payload widths, rounded up to whole bytes
	localparam int S_DATA_W = ((SEQ_W + LEN_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((SEQ_W + BYTES_W + 7) / 8) * 8;

	localparam logic [BYTES_W-1:0] CAP_RESET = 16'd4096;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 8'd1;

	// Result outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_DELIVERED = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_BUFFERED  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_DUPLICATE = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_EMPTY     = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_FIN       = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_NOT_OPEN  = 3'd5;
	localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd6;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

### hw/rtl/segment_reorder_receiver_unit.sv
// ----------------------------------------------------------------------------
// segment_reorder_receiver_unit
// Receive side of a selective-repeat scheme: expected sequence tracking with
// an out-of-order slot table held in a synchronous memory.
// ----------------------------------------------------------------------------
// s_* takes one segment descriptor per transaction (s_tlast is the finish
// flag, s_tdata the sequence number and length); m_* returns one result per
// segment (m_tuser the outcome, m_tdata the ack number and delivered bytes).
// cfg_* writes the start sequence number (index 0, also loads the expected
// number) and the delivery capacity (index 1); cfg_ready is always high.
// Closed, finish and empty segments go straight to the finish state. An
// out-of-order segment first runs the one-read-per-slot duplicate scan and
// the slot write; an in-order segment first runs the drain passes over the
// single read port. One segment is in the sequencer at a time.
// Reset clears the expected number to 0, opens the block, empties the slot
// table and sets the capacity to 4096; the slot memory itself is not cleared.
// While m_tready is low a result waits in the output register; the next
// segment is still taken and waits in the finish state until it frees.
// ----------------------------------------------------------------------------
module segment_reorder_receiver_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Segment input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [srr_pkg::S_DATA_W-1:0]      s_tdata,   // seg_seq[31:0], seg_len[42:32]
	input  logic                              s_tlast,   // fin
	// Result output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [srr_pkg::M_DATA_W-1:0]      m_tdata,   // ack_number[31:0], delivered_bytes[47:32]
	output logic [srr_pkg::OUTCOME_W-1:0]     m_tuser,   // outcome[2:0]
	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srr_pkg::CFG_W-1:0]         cfg_data
);

	import srr_pkg::*;

	`include "segment_reorder_receiver_unit_assert.svh"

	// Slot memory: sequence number in the upper bits, length in the lower
	logic [ENTRY_W-1:0]   mem [SLOTS];

	state_t               state_q, state_d;

	logic [SEQ_W-1:0]     exp_q;
	logic                 open_q;
	logic [BYTES_W-1:0]   cap_q;
	logic [SLOTS-1:0]     valid_q;

	logic [SEQ_W-1:0]     seg_seq_q;
	logic [LEN_W-1:0]     seg_len_q;
	logic [BYTES_W-1:0]   copied_q;
	logic                 dup_q;

	logic [OUTCOME_W-1:0] res_outcome_q;
	logic [SEQ_W-1:0]     res_ack_q;
	logic [BYTES_W-1:0]   res_bytes_q;

	// Read issue side of the slot sweep
	logic                 rd_go_q;
	logic [SLOT_W-1:0]    rd_idx_q;
	logic [PASS_W-1:0]    rd_pass_q;
	logic                 rd_last;

	// Compare side, in the cycle after the read issue
	logic                 cmp_vld_s1;
	logic [SLOT_W-1:0]    cmp_idx_s1;
	logic                 cmp_last_s1;
	logic [ENTRY_W-1:0]   rd_data_s1;

	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic [OUTCOME_W-1:0] m_tuser_q;

	logic [SEQ_W-1:0]     in_seq;
	logic [LEN_W-1:0]     in_len_raw;
	logic [LEN_W-1:0]     in_len;
	logic                 s_acc;
	logic                 out_free;

	logic [SEQ_W-1:0]     rd_seq;
	logic [LEN_W-1:0]     rd_len;
	logic                 hit;
	logic [BYTES_W-1:0]   room;
	logic [BYTES_W-1:0]   take;
	logic [SEQ_W-1:0]     exp_step;
	logic [BYTES_W-1:0]   copied_step;
	logic [BYTES_W-1:0]   first_copy;

	logic                 free_any;
	logic [SLOT_W-1:0]    free_idx;
	logic                 mem_we;

	// Unpack the input payload and saturate the length
	assign in_seq     = s_tdata[SEQ_W-1:0];
	assign in_len_raw = s_tdata[SEQ_W+LEN_W-1:SEQ_W];
	assign in_len     = (int'(in_len_raw) > MAX_SEGMENT) ? LEN_W'(MAX_SEGMENT) : in_len_raw;
	assign first_copy = ({{(BYTES_W-LEN_W){1'b0}}, in_len} > cap_q) ?
	                    cap_q : {{(BYTES_W-LEN_W){1'b0}}, in_len};

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Compare the slot read back against the scan or drain target
	assign rd_seq = rd_data_s1[ENTRY_W-1:LEN_W];
	assign rd_len = rd_data_s1[LEN_W-1:0];
	assign hit    = cmp_vld_s1 && valid_q[cmp_idx_s1] &&
	                (rd_seq == ((state_q == ST_SCAN) ? seg_seq_q : exp_q));

	// Clip the drained length to what is left of the capacity
	assign room        = cap_q - copied_q;
	assign take        = ({{(BYTES_W-LEN_W){1'b0}}, rd_len} > room) ?
	                     room : {{(BYTES_W-LEN_W){1'b0}}, rd_len};
	assign exp_step    = hit ? (exp_q + {{(SEQ_W-LEN_W){1'b0}}, rd_len}) : exp_q;
	assign copied_step = hit ? (copied_q + take) : copied_q;

	// Last read of the sweep: last slot of the scan or of the final pass
	assign rd_last = (rd_idx_q == SLOT_W'(SLOTS - 1)) &&
	                 ((state_q == ST_SCAN) || (rd_pass_q == PASS_W'(DRAIN_PASSES - 1)));

	// Find the lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign mem_we = (state_q == ST_SCAN) && cmp_last_s1 && !(dup_q || hit) && free_any;

	// Slot memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx] <= {seg_seq_q, seg_len_q};
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					priority if (!open_q || s_tlast || (in_len == '0)) begin
						state_d = ST_FINISH;
					end else if (in_seq != exp_q) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_SCAN, ST_DRAIN: begin
				if (cmp_last_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep read issue and compare pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_go_q     <= 1'b0;
			rd_idx_q    <= '0;
			rd_pass_q   <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			cmp_last_s1 <= 1'b0;
		end else begin
			cmp_vld_s1  <= rd_go_q;
			cmp_idx_s1  <= rd_idx_q;
			cmp_last_s1 <= rd_go_q && rd_last;
			if (s_acc) begin
				rd_go_q   <= open_q && !s_tlast && (in_len != '0);
				rd_idx_q  <= '0;
				rd_pass_q <= '0;
			end else if (rd_go_q) begin
				if (rd_last) begin
					rd_go_q <= 1'b0;
				end
				if (rd_idx_q == SLOT_W'(SLOTS - 1)) begin
					rd_idx_q  <= '0;
					rd_pass_q <= rd_pass_q + 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	// Control state: expected number, open flag, capacity, slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= '0;
			open_q  <= 1'b1;
			cap_q   <= CAP_RESET;
			valid_q <= '0;
			dup_q   <= 1'b0;
		end else begin
			// Configuration transactions
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_START_SEQ) begin
					exp_q <= cfg_data[SEQ_W-1:0];
				end else if (cfg_index == CFG_CAPACITY) begin
					cap_q <= cfg_data[BYTES_W-1:0];
				end
			end
			// Segment acceptance
			if (s_acc && open_q) begin
				dup_q <= 1'b0;
				if (s_tlast) begin
					exp_q  <= in_seq + 1'b1;
					open_q <= 1'b0;
				end else if ((in_len != '0) && (in_seq == exp_q)) begin
					exp_q <= in_seq + {{(SEQ_W-LEN_W){1'b0}}, in_len};
				end
			end
			// Duplicate scan
			if ((state_q == ST_SCAN) && hit) begin
				dup_q <= 1'b1;
			end
			if (mem_we) begin
				valid_q[free_idx] <= 1'b1;
			end
			// Drain: advance and release matched slots
			if ((state_q == ST_DRAIN) && hit) begin
				exp_q               <= exp_step;
				valid_q[cmp_idx_s1] <= 1'b0;
			end
		end
	end

	// Segment payload, delivered count and result registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			seg_seq_q <= in_seq;
			seg_len_q <= in_len;
			copied_q  <= first_copy;
			res_bytes_q <= '0;
			priority if (!open_q) begin
				res_outcome_q <= OUT_NOT_OPEN;
				res_ack_q     <= '0;
			end else if (s_tlast) begin
				res_outcome_q <= OUT_FIN;
				res_ack_q     <= in_seq + 1'b1;
			end else begin
				res_outcome_q <= OUT_EMPTY;
				res_ack_q     <= '0;
			end
		end
		if (state_q == ST_DRAIN) begin
			copied_q <= copied_step;
			if (cmp_last_s1) begin
				res_outcome_q <= OUT_DELIVERED;
				res_ack_q     <= exp_step;
				res_bytes_q   <= copied_step;
			end
		end
		if ((state_q == ST_SCAN) && cmp_last_s1) begin
			priority if (dup_q || hit) begin
				res_outcome_q <= OUT_DUPLICATE;
			end else if (free_any) begin
				res_outcome_q <= OUT_BUFFERED;
			end else begin
				res_outcome_q <= OUT_FULL;
			end
		end
	end

	// Output register: load the finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			m_tdata_q <= {{(M_DATA_W-SEQ_W-BYTES_W){1'b0}}, res_bytes_q, res_ack_q};
			m_tuser_q <= res_outcome_q;
		end
	end

	// Assertions
	`SRR_ASSERT(a_cmp_in_sweep, clk, arst_n,
		!cmp_vld_s1 || (state_q == ST_SCAN) || (state_q == ST_DRAIN),
		"slot compare outside a scan or drain")
	`SRR_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, s_acc,
		state_q != ST_IDLE, "accepted segment did not start the sequencer")
	`SRR_ASSERT_NEXT(a_scan_keeps_slots, clk, arst_n, state_q == ST_SCAN,
		$countones(valid_q) >= $past($countones(valid_q)), "slot released during a scan")
	`SRR_ASSERT(a_single_write, clk, arst_n,
		!mem_we || !valid_q[free_idx], "slot memory write into an occupied slot")

endmodule

### sim/segment_reorder_receiver_unit_checker.sv
// ----------------------------------------------------------------------------
// segment_reorder_receiver_unit_checker
// Watches the segment, result and configuration channels of the reorder
// receiver, predicts the outcome, ack number and delivered byte count of
// every accepted segment and compares each returned result with the oldest
// prediction. Reports the failure count and the number of results still owed.
// ----------------------------------------------------------------------------
module segment_reorder_receiver_unit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [srr_pkg::S_DATA_W-1:0]  s_tdata,   // seg_seq[31:0], seg_len[42:32]
	input  logic                          s_tlast,   // fin
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [srr_pkg::M_DATA_W-1:0]  m_tdata,   // ack_number[31:0], delivered_bytes[47:32]
	input  logic [srr_pkg::OUTCOME_W-1:0] m_tuser,   // outcome[2:0]
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [srr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srr_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            outstanding
);

	import srr_pkg::*;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [SEQ_W-1:0]     ack;
		logic [BYTES_W-1:0]   bytes;
	} reply_t;

	// Receiver state as the block should hold it
	logic [SEQ_W-1:0]   next_seq;
	logic               conn_open;
	logic [SLOTS-1:0]   held;
	logic [SEQ_W-1:0]   held_seq [SLOTS];
	logic [LEN_W-1:0]   held_len [SLOTS];
	logic [BYTES_W-1:0] capacity;

	reply_t             pending_acks [$];
	int                 errors;

	// Apply one segment to the receiver state and return the reply it earns
	function automatic reply_t receive_segment(input logic fin, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len_field);
		reply_t           r;
		logic [SEQ_W-1:0] len;
		logic [SEQ_W-1:0] room;
		logic [SEQ_W-1:0] take;
		logic [SEQ_W-1:0] copied;
		r = '0;
		len = (len_field > MAX_SEGMENT) ? SEQ_W'(MAX_SEGMENT) : SEQ_W'(len_field);
		if (!conn_open) begin
			r.outcome = OUT_NOT_OPEN;
			return r;
		end
		// Finish wins over the length check
		if (fin) begin
			next_seq = seq + 1'b1;
			conn_open = 1'b0;
			r.outcome = OUT_FIN;
			r.ack = next_seq;
			return r;
		end
		if (len == '0) begin
			r.outcome = OUT_EMPTY;
			return r;
		end
		// Out of order: drop a duplicate, else take the lowest free slot
		if (seq != next_seq) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (held[i] && held_seq[i] == seq) begin
					r.outcome = OUT_DUPLICATE;
					return r;
				end
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (!held[i]) begin
					held[i] = 1'b1;
					held_seq[i] = seq;
					held_len[i] = len[LEN_W-1:0];
					r.outcome = OUT_BUFFERED;
					return r;
				end
			end
			r.outcome = OUT_FULL;
			return r;
		end
		// In order: advance, then drain successors in slot order
		next_seq = seq + len;
		copied = (len > capacity) ? SEQ_W'(capacity) : len;
		for (int p = 0; p < DRAIN_PASSES; p++) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (held[i] && held_seq[i] == next_seq) begin
					room = SEQ_W'(capacity) - copied;
					take = (SEQ_W'(held_len[i]) > room) ? room : SEQ_W'(held_len[i]);
					next_seq = next_seq + held_len[i];
					copied = copied + take;
					held[i] = 1'b0;
				end
			end
		end
		r.outcome = OUT_DELIVERED;
		r.ack = next_seq;
		r.bytes = copied[BYTES_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			next_seq = '0;
			conn_open = 1'b1;
			held = '0;
			capacity = CAP_RESET;
			pending_acks.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_START_SEQ)
					next_seq = cfg_data[SEQ_W-1:0];
				else if (cfg_index == CFG_CAPACITY)
					capacity = cfg_data[BYTES_W-1:0];
			end
			// Compare a returned result with the oldest prediction
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[SEQ_W-1:0], m_tdata[SEQ_W +: BYTES_W]};
				if (pending_acks.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: outcome %0d ack %h bytes %0d",
							got.outcome, got.ack, got.bytes);
				end else begin
					want = pending_acks.pop_front();
					if (want !== got) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch (exp/got): outcome %0d/%0d, ",
								"ack %h/%h, bytes %0d/%0d"},
								want.outcome, got.outcome, want.ack, got.ack,
								want.bytes, got.bytes);
					end
				end
			end
			// Predict the reply to an accepted segment
			if (s_tvalid && s_tready)
				pending_acks.push_back(receive_segment(s_tlast, s_tdata[SEQ_W-1:0],
					s_tdata[SEQ_W +: LEN_W]));
			fail_count <= errors;
			outstanding <= pending_acks.size();
		end
	end

endmodule

### sim/segment_reorder_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// segment_reorder_receiver_unit_tb
// Drives segment windows into the reorder receiver: directed corner cases,
// then random windows sent in order, reversed or shuffled with duplicates and
// noise, retransmitted from the returned ack and swept clean afterwards.
// Both stream sides pause at random; the checker judges every result.
// ----------------------------------------------------------------------------
module segment_reorder_receiver_unit_tb;
	import srr_pkg::*;

	localparam int                   SEG_GOAL    = 1450;
	localparam int                   STALL_LIMIT = 2000;
	localparam int                   DRAIN_WAIT  = 30;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 8'hFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;    // seg_seq[31:0], seg_len[42:32]
	logic                 s_tlast = 1'b0;  // fin
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;         // ack_number[31:0], delivered_bytes[47:32]
	logic [OUTCOME_W-1:0] m_tuser;         // outcome[2:0]
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int                   fail_count;
	int                   outstanding;
	int                   items_sent = 0;
	int                   deliveries = 0;
	logic [SEQ_W-1:0]     delivered_ack = '0;
	int                   idle_cycles = 0;
	int                   tx_calm = 0;
	int                   rx_calm = 0;
	int                   rx_hold = 0;
	logic [SEQ_W-1:0]     loose_seqs [$];

	segment_reorder_receiver_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	segment_reorder_receiver_unit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Pause length: mostly none or short, a few long, with calm stretches
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Throttle the result side
	always @(posedge clk) begin
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			stall = pick_gap(rx_calm);
			m_tready <= (stall == 0);
			rx_hold <= (stall == 0) ? $urandom_range(0, 4) : stall - 1;
		end
	end

	// Remember the latest cumulative ack
	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tuser == OUT_DELIVERED) begin
			delivered_ack <= m_tdata[SEQ_W-1:0];
			deliveries <= deliveries + 1;
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one segment and hold it until taken
	task automatic send_seg(input logic fin, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tlast <= fin;
		s_tdata <= S_DATA_W'({len, seq});
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Drop valid and wait until every result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Empty any slot that may still hold one of the listed sequence numbers:
	// land the expected number on it with a one-byte segment just before
	task automatic flush_slots();
		logic [SEQ_W-1:0] s;
		while (loose_seqs.size() > 0) begin
			s = loose_seqs.pop_front();
			write_reg(CFG_START_SEQ, s - 1'b1);
			send_seg(1'b0, s - 1'b1, 11'd1);
		end
	endtask

	// One window of contiguous segments, sent out of order with noise, then
	// retransmitted from the returned ack until the window is complete
	task automatic run_window(input int w);
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] ack;
		logic [SEQ_W-1:0] off;
		logic [SEQ_W-1:0] total;
		logic [SEQ_W-1:0] s;
		logic [CFG_W-1:0] cap_word;
		logic [LEN_W-1:0] len;
		logic [SEQ_W-1:0] offs [$];
		logic [LEN_W-1:0] lens [$];
		int               order [$];
		int               n, mode, r, j, tmp, d0, pick;
		bit               found;

		// Capacity: extremes first, then random now and then
		if (w < 3 || $urandom_range(0, 99) < 40) begin
			cap_word = $urandom();
			r = $urandom_range(0, 99);
			case (w)
				0: cap_word[15:0] = 16'h0000;
				1: cap_word[15:0] = 16'hFFFF;
				2: cap_word[15:0] = 16'h0001;
				default: begin
					if (r < 20)
						cap_word[15:0] = CAP_RESET;
					else if (r < 60)
						cap_word[15:0] = BYTES_W'($urandom_range(1, 2000));
					else if (r < 65)
						cap_word[15:0] = 16'h0000;
				end
			endcase
			write_reg(CFG_CAPACITY, cap_word);
		end

		r = $urandom_range(0, 99);
		case (w)
			0: base = '0;
			1: base = 32'hFFFFFFFF;
			2: base = 32'hFFFFF000;
			default: base = (r < 15) ? 32'hFFFFFFFF - $urandom_range(0, 4000) : $urandom();
		endcase

		// Lay out the window, saturated length decides the offsets
		n = ($urandom_range(0, 99) < 15) ? $urandom_range(9, 12) : $urandom_range(1, 8);
		total = '0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 11'd1;
			else if (r < 16)
				len = LEN_W'($urandom_range(MAX_SEGMENT + 1, 2047));
			else if (r < 20)
				len = LEN_W'(MAX_SEGMENT);
			else
				len = LEN_W'($urandom_range(1, MAX_SEGMENT));
			offs.push_back(total);
			lens.push_back(len);
			total = total + ((len > MAX_SEGMENT) ? SEQ_W'(MAX_SEGMENT) : SEQ_W'(len));
			order.push_back(i);
		end

		mode = (n > SLOTS) ? $urandom_range(1, 2) : $urandom_range(0, 3);
		if (mode == 1) begin
			order.reverse();
		end else if (mode == 2) begin
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end else if (mode == 3) begin
			for (int i = 0; i + 1 < n; i += 2) begin
				if ($urandom_range(0, 1)) begin
					tmp = order[i];
					order[i] = order[i + 1];
					order[i + 1] = tmp;
				end
			end
		end

		write_reg(CFG_START_SEQ, base);
		d0 = deliveries;

		// First transmission, with empty, repeated and stray segments mixed in
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 15) begin
				r = $urandom_range(0, 99);
				if (r < 85 && r >= 55 && k > 0) begin
					pick = order[$urandom_range(0, k - 1)];
					send_seg(1'b0, base + offs[pick], lens[pick]);
				end else if (r >= 85) begin
					s = $urandom();
					send_seg(1'b0, s, LEN_W'($urandom_range(1, 2047)));
					loose_seqs.push_back(s);
				end else begin
					s = ($urandom_range(0, 1)) ? base + offs[$urandom_range(0, n - 1)] : $urandom();
					send_seg(1'b0, s, 11'd0);
				end
			end
			send_seg(1'b0, base + offs[order[k]], lens[order[k]]);
			loose_seqs.push_back(base + offs[order[k]]);
		end
		settle();

		// Retransmit the segment the ack asks for until the window is done
		for (int k = 0; k <= n; k++) begin
			ack = (deliveries != d0) ? delivered_ack : base;
			off = ack - base;
			if (off >= total)
				break;
			found = 1'b0;
			foreach (offs[i]) begin
				if (!found && offs[i] == off) begin
					found = 1'b1;
					tmp = i;
				end
			end
			if (!found)
				break;
			send_seg(1'b0, base + offs[tmp], lens[tmp]);
			settle();
		end

		flush_slots();
	endtask

	initial begin
		int w;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty segment, oversized in-order segment
		send_seg(1'b0, 32'd0, 11'd0);
		send_seg(1'b0, 32'd0, 11'h7FF);
		// Fill the table backwards, overflow it, repeat a held one
		for (int k = 9; k >= 1; k--) begin
			send_seg(1'b0, 32'd1024 + 32'd100 * k, 11'd100);
			loose_seqs.push_back(32'd1024 + 32'd100 * k);
		end
		send_seg(1'b0, 32'd1524, 11'd100);
		// In order without a successor, then with a two-pass drain
		send_seg(1'b0, 32'd1024, 11'd100);
		send_seg(1'b0, 32'd1124, 11'd100);
		flush_slots();

		w = 0;
		while (items_sent < SEG_GOAL) begin
			run_window(w);
			w++;
		end

		// Writes to registers that do not exist
		write_reg(CFG_SPARE, $urandom());
		write_reg(CFG_IDX_W'($urandom_range(2, 254)), $urandom());

		// Finish closes the connection; everything after is refused
		write_reg(CFG_START_SEQ, $urandom());
		send_seg(1'b1, 32'hFFFFFFFF, 11'd0);
		send_seg(1'b0, 32'd0, 11'd5);
		send_seg(1'b0, $urandom(), 11'd0);
		send_seg(1'b1, $urandom(), 11'h7FF);
		write_reg(CFG_START_SEQ, '0);
		send_seg(1'b0, 32'd0, 11'd10);
		settle();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
